### hdl/fcsg_pkg.sv
package fcsg_pkg;

  // Field widths
  localparam int CoordInW  = 12;
  localparam int CoordOutW = 14;
  localparam int ColourW   = 24;
  localparam int RadiusW   = 5;

  // Largest radius the walk runs at; larger settings saturate here
  localparam int MaxRadius = 16;
  localparam logic [RadiusW-1:0] RadiusMax   = RadiusW'(MaxRadius);
  localparam logic [RadiusW-1:0] RadiusMin   = RadiusW'(1);
  localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(2);

  // Walk variable widths
  localparam int PosW  = 6;   // x, y (signed)
  localparam int StepW = 7;   // dx, dy (unsigned)
  localparam int ErrW  = 9;   // error term (signed)

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } fsm_state_t;

  // Which of the four spans of one walk step is being issued
  typedef enum logic [1:0] {
    PH_LOWER_Y,
    PH_UPPER_Y,
    PH_LOWER_X,
    PH_UPPER_X
  } span_phase_t;

  typedef struct packed {
    logic        load;
    logic        emit;
    span_phase_t phase;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic walk_end;
  } dp_status_t;

endpackage

### hdl/fcsg_ctrl.sv
module fcsg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcsg_pkg::dp_status_t status,
  output fcsg_pkg::dp_cmd_t    cmd
);
  import fcsg_pkg::*;

  fsm_state_t  state_r, state_nxt;
  span_phase_t phase_r, phase_nxt;

  // State and phase registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_LOWER_Y;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    in_stall  = 1'b1;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.phase = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
          phase_nxt = PH_LOWER_Y;
        end
      end
      ST_WALK: begin
        // Issue one span whenever the output word is free or being taken
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          unique case (phase_r)
            PH_LOWER_Y: phase_nxt = PH_UPPER_Y;
            PH_UPPER_Y: phase_nxt = PH_LOWER_X;
            PH_LOWER_X: phase_nxt = PH_UPPER_X;
            PH_UPPER_X: begin
              phase_nxt = PH_LOWER_Y;
              if (status.walk_end) state_nxt = ST_IDLE;
            end
            default: phase_nxt = PH_LOWER_Y;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hdl/fcsg_datapath.sv
module fcsg_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  input  logic [fcsg_pkg::RadiusW-1:0]           cfg_circle_radius,
  input  fcsg_pkg::dp_cmd_t                      cmd,
  output fcsg_pkg::dp_status_t                   status,
  input  logic [fcsg_pkg::CoordInW-1:0]          in_centre_x,
  input  logic [fcsg_pkg::CoordInW-1:0]          in_centre_y,
  input  logic [fcsg_pkg::ColourW-1:0]           in_colour,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [fcsg_pkg::CoordOutW-1:0]  out_span_start_x,
  output logic signed [fcsg_pkg::CoordOutW-1:0]  out_span_end_x,
  output logic signed [fcsg_pkg::CoordOutW-1:0]  out_span_row,
  output logic [fcsg_pkg::ColourW-1:0]           out_span_colour,
  output logic                                   out_last_span
);
  import fcsg_pkg::*;

  logic [RadiusW-1:0]          radius_r;
  logic [RadiusW-1:0]          radius_sat;
  logic [RadiusW:0]            diam_r;
  logic [CoordInW-1:0]         cx_r, cy_r;
  logic [ColourW-1:0]          colour_r;
  logic signed [PosW-1:0]      x_r, y_r, x_nxt, y_nxt;
  logic [StepW-1:0]            dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [ErrW-1:0]      err_r, err_mid, err_nxt;
  logic signed [CoordOutW-1:0] cx_s, cy_s, x_s, y_s;
  logic signed [CoordOutW-1:0] start_nxt, end_nxt, row_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [CoordOutW-1:0] start_r, end_r, row_r;
  logic [ColourW-1:0]          span_colour_r;
  logic                        last_r;

  // Radius register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RadiusReset;
    end else if (cfg_valid) begin
      radius_r <= cfg_circle_radius;
    end
  end

  // Saturate the radius into the supported range
  always_comb begin
    if (radius_r < RadiusMin) begin
      radius_sat = RadiusMin;
    end else if (radius_r > RadiusMax) begin
      radius_sat = RadiusMax;
    end else begin
      radius_sat = radius_r;
    end
  end

  // One midpoint step: advance y if the error is not positive, then pull x in if the error is then positive
  always_comb begin
    y_nxt   = y_r;
    dy_nxt  = dy_r;
    err_mid = err_r;
    if (err_r <= 0) begin
      y_nxt   = y_r + PosW'(1);
      err_mid = err_r + signed'(ErrW'(dy_r));
      dy_nxt  = dy_r + StepW'(2);
    end
    x_nxt   = x_r;
    dx_nxt  = dx_r;
    err_nxt = err_mid;
    if (err_mid > 0) begin
      x_nxt   = x_r - PosW'(1);
      dx_nxt  = dx_r + StepW'(2);
      err_nxt = err_mid + signed'(ErrW'(dx_nxt)) - signed'(ErrW'(diam_r));
    end
  end

  assign status.walk_end  = (x_nxt < y_nxt);
  assign status.slot_free = !out_valid_r || !out_stall;

  // Walk registers: seed on load, step after the fourth span
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r     <= in_centre_x;
      cy_r     <= in_centre_y;
      colour_r <= in_colour;
      diam_r   <= {radius_sat, 1'b0};
      x_r      <= signed'(PosW'(radius_sat)) - PosW'(1);
      y_r      <= '0;
      dx_r     <= StepW'(1);
      dy_r     <= StepW'(1);
      err_r    <= ErrW'(1) - signed'(ErrW'({radius_sat, 1'b0}));
    end else if (cmd.emit && cmd.phase == PH_UPPER_X) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      err_r <= err_nxt;
    end
  end

  // Span for the current phase
  assign cx_s = signed'({2'b00, cx_r});
  assign cy_s = signed'({2'b00, cy_r});
  assign x_s  = {{(CoordOutW-PosW){x_r[PosW-1]}}, x_r};
  assign y_s  = {{(CoordOutW-PosW){y_r[PosW-1]}}, y_r};

  always_comb begin
    case (cmd.phase)
      PH_LOWER_Y: begin
        start_nxt = cx_s - x_s;
        end_nxt   = cx_s + x_s;
        row_nxt   = cy_s + y_s;
      end
      PH_UPPER_Y: begin
        start_nxt = cx_s - x_s;
        end_nxt   = cx_s + x_s;
        row_nxt   = cy_s - y_s;
      end
      PH_LOWER_X: begin
        start_nxt = cx_s - y_s;
        end_nxt   = cx_s + y_s;
        row_nxt   = cy_s + x_s;
      end
      default: begin
        start_nxt = cx_s - y_s;
        end_nxt   = cx_s + y_s;
        row_nxt   = cy_s - x_s;
      end
    endcase
  end

  // Output word: hold while stalled, drop once taken
  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      start_r       <= start_nxt;
      end_r         <= end_nxt;
      row_r         <= row_nxt;
      span_colour_r <= colour_r;
      last_r        <= (cmd.phase == PH_UPPER_X) && status.walk_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_span_start_x = start_r;
  assign out_span_end_x   = end_r;
  assign out_span_row     = row_r;
  assign out_span_colour  = span_colour_r;
  assign out_last_span    = last_r;

endmodule

### hdl/filled_circle_span_generator_unit.sv
// Filled circle span generator. Each accepted word (centre and colour) is
// expanded by a midpoint circle walk at the configured radius into
// horizontal spans, four per walk step, one span per cycle while the
// output is not stalled; the final span of a circle carries out_last_span.
// A circle whose walk takes S steps yields 4*S spans, all issued by the
// single span adder path (S is at most the saturated radius, so at most
// 64 spans). A new word is accepted in the cycle after the last span is
// issued, even while that span still waits in the output register. The
// radius saturates to 1..16; write it only while the block is idle. No
// clearing pass.
module filled_circle_span_generator_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fcsg_pkg::RadiusW-1:0]           cfg_circle_radius,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [fcsg_pkg::CoordInW-1:0]          in_centre_x,
  input  logic [fcsg_pkg::CoordInW-1:0]          in_centre_y,
  input  logic [fcsg_pkg::ColourW-1:0]           in_colour,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [fcsg_pkg::CoordOutW-1:0]  out_span_start_x,
  output logic signed [fcsg_pkg::CoordOutW-1:0]  out_span_end_x,
  output logic signed [fcsg_pkg::CoordOutW-1:0]  out_span_row,
  output logic [fcsg_pkg::ColourW-1:0]           out_span_colour,
  output logic                                   out_last_span
);
  import fcsg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Radius writes are always taken
  assign cfg_ready = 1'b1;

  fcsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fcsg_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_circle_radius (cfg_circle_radius),
    .cmd               (cmd),
    .status            (status),
    .in_centre_x       (in_centre_x),
    .in_centre_y       (in_centre_y),
    .in_colour         (in_colour),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_span_start_x  (out_span_start_x),
    .out_span_end_x    (out_span_end_x),
    .out_span_row      (out_span_row),
    .out_span_colour   (out_span_colour),
    .out_last_span     (out_last_span)
  );

  // An accepted word always starts a walk
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // The block reopens only once the closing span has been issued
  a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && $past(in_stall) && $past(rst_n)) |-> (out_valid && out_last_span))
    else $error("input reopened without a closing span");

  // While open for input, any pending output word is a closing span
  a_idle_holds_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && out_valid) |-> out_last_span)
    else $error("non-final span pending while idle");

endmodule

### dv/tb.sv
module tb;
  import fcsg_pkg::*;

  localparam int RandomCircles = 440;
  localparam int DrainCycles   = 4;
  localparam int TailCycles    = 80;
  localparam int HangLimit     = 5000;
  localparam int MaxReports    = 40;

  typedef enum logic {
    JOB_CIRCLE,
    JOB_RADIUS
  } job_kind_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_t;

  typedef struct {
    job_kind_t             kind;
    logic [CoordInW-1:0]   cx;
    logic [CoordInW-1:0]   cy;
    logic [ColourW-1:0]    colour;
    logic [RadiusW-1:0]    radius;
  } job_t;

  typedef struct packed {
    logic signed [CoordOutW-1:0] start_x;
    logic signed [CoordOutW-1:0] end_x;
    logic signed [CoordOutW-1:0] row;
    logic [ColourW-1:0]          colour;
    logic                        last_span;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [RadiusW-1:0]           cfg_circle_radius = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [CoordInW-1:0]          in_centre_x = '0;
  logic [CoordInW-1:0]          in_centre_y = '0;
  logic [ColourW-1:0]           in_colour = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [CoordOutW-1:0]  out_span_start_x;
  logic signed [CoordOutW-1:0]  out_span_end_x;
  logic signed [CoordOutW-1:0]  out_span_row;
  logic [ColourW-1:0]           out_span_colour;
  logic                         out_last_span;

  job_t   circle_jobs[$];
  span_t  expected_spans[$];
  logic [RadiusW-1:0] radius_shadow = RadiusReset;

  logic in_fired = 1'b0;
  logic cfg_fired = 1'b0;
  int   fail_count = 0;
  int   report_count = 0;
  int   idle_cycles = 0;

  // sender pacing
  int burst_left = 1;
  int gap_left = 0;
  int quiet_cycles = 0;

  // receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int   stall_span_left = 0;
  int   stall_run_left = 0;
  logic stall_held = 1'b0;

  filled_circle_span_generator_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_circle_radius (cfg_circle_radius),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_centre_x       (in_centre_x),
    .in_centre_y       (in_centre_y),
    .in_colour         (in_colour),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_span_start_x  (out_span_start_x),
    .out_span_end_x    (out_span_end_x),
    .out_span_row      (out_span_row),
    .out_span_colour   (out_span_colour),
    .out_last_span     (out_last_span)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the midpoint circle for one centre and queue the spans it yields
  function automatic void predict_circle_spans(logic [CoordInW-1:0] cx,
                                               logic [CoordInW-1:0] cy,
                                               logic [ColourW-1:0] colour,
                                               logic [RadiusW-1:0] radius);
    int    rad, px, py, step_x, step_y, err, count, ccx, ccy;
    span_t s;
    rad = int'(radius);
    if (rad < int'(RadiusMin)) rad = int'(RadiusMin);
    if (rad > MaxRadius) rad = MaxRadius;
    ccx = int'(cx);
    ccy = int'(cy);
    px = rad - 1;
    py = 0;
    step_x = 1;
    step_y = 1;
    err = step_x - 2 * rad;
    count = 0;
    s.colour = colour;
    s.last_span = 1'b0;
    while (px >= py && count + 4 <= 4 * MaxRadius) begin
      s.start_x = CoordOutW'(ccx - px);
      s.end_x   = CoordOutW'(ccx + px);
      s.row     = CoordOutW'(ccy + py);
      expected_spans = {expected_spans, s};
      s.row     = CoordOutW'(ccy - py);
      expected_spans = {expected_spans, s};
      s.start_x = CoordOutW'(ccx - py);
      s.end_x   = CoordOutW'(ccx + py);
      s.row     = CoordOutW'(ccy + px);
      expected_spans = {expected_spans, s};
      s.row     = CoordOutW'(ccy - px);
      expected_spans = {expected_spans, s};
      count += 4;
      if (err <= 0) begin
        py++;
        err += step_y;
        step_y += 2;
      end
      if (err > 0) begin
        px--;
        step_x += 2;
        err += step_x - 2 * rad;
      end
    end
    // flag the closing span of this circle
    s = expected_spans.pop_back();
    s.last_span = 1'b1;
    expected_spans = {expected_spans, s};
  endfunction

  function automatic void add_circle(logic [CoordInW-1:0] cx, logic [CoordInW-1:0] cy,
                                     logic [ColourW-1:0] colour);
    job_t j;
    j.kind = JOB_CIRCLE;
    j.cx = cx;
    j.cy = cy;
    j.colour = colour;
    j.radius = '0;
    circle_jobs = {circle_jobs, j};
  endfunction

  function automatic void add_radius(logic [RadiusW-1:0] radius);
    job_t j;
    j.kind = JOB_RADIUS;
    j.cx = '0;
    j.cy = '0;
    j.colour = '0;
    j.radius = radius;
    circle_jobs = {circle_jobs, j};
  endfunction

  // Favour the edges so that spans cross below 0 and past 4095
  function automatic logic [CoordInW-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return CoordInW'($urandom_range(0, 20));
      1: return CoordInW'($urandom_range(4075, 4095));
      default: return CoordInW'($urandom);
    endcase
  endfunction

  // Sample handshakes, track the radius and check every span word
  always @(posedge clk) begin
    span_t got, want;
    if (!rst_n) begin
      in_fired <= 1'b0;
      cfg_fired <= 1'b0;
      radius_shadow <= RadiusReset;
    end else begin
      in_fired <= in_valid && !in_stall;
      cfg_fired <= cfg_valid && cfg_ready;
      if (out_valid && !out_stall) begin
        got.start_x = out_span_start_x;
        got.end_x = out_span_end_x;
        got.row = out_span_row;
        got.colour = out_span_colour;
        got.last_span = out_last_span;
        if (expected_spans.size() == 0) begin
          fail_count++;
          if (report_count < MaxReports) begin
            report_count++;
            $display("%0t: unexpected span start %0d end %0d row %0d colour %h last %b",
                     $time, got.start_x, got.end_x, got.row, got.colour, got.last_span);
          end
        end else begin
          want = expected_spans.pop_front();
          if (got !== want) begin
            fail_count++;
            if (report_count < MaxReports) begin
              report_count++;
              $display("%0t: span mismatch expected start %0d end %0d row %0d colour %h last %b",
                       $time, want.start_x, want.end_x, want.row, want.colour,
                       want.last_span);
              $display("%0t:                actual start %0d end %0d row %0d colour %h last %b",
                       $time, got.start_x, got.end_x, got.row, got.colour, got.last_span);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) radius_shadow <= cfg_circle_radius;
      if (in_valid && !in_stall)
        predict_circle_spans(in_centre_x, in_centre_y, in_colour, radius_shadow);
    end
  end

  // Feed circles in bursts; hold radius writes until the block has drained
  always @(negedge clk) begin
    job_t j;
    logic nxt_in_valid, nxt_cfg_valid;
    nxt_in_valid = in_valid;
    nxt_cfg_valid = cfg_valid;
    if (rst_n) begin
      if (in_valid && in_fired) nxt_in_valid = 1'b0;
      if (cfg_valid && cfg_fired) nxt_cfg_valid = 1'b0;
      if (expected_spans.size() == 0 && !in_valid && !cfg_valid) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (circle_jobs.size() > 0) begin
          if (circle_jobs[0].kind == JOB_CIRCLE) begin
            j = circle_jobs.pop_front();
            nxt_in_valid = 1'b1;
            in_centre_x <= j.cx;
            in_centre_y <= j.cy;
            in_colour <= j.colour;
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 12);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
              burst_left--;
            end
          end else if (quiet_cycles >= DrainCycles) begin
            j = circle_jobs.pop_front();
            nxt_cfg_valid = 1'b1;
            cfg_circle_radius <= j.radius;
          end
        end
      end
    end
    in_valid <= nxt_in_valid;
    cfg_valid <= nxt_cfg_valid;
  end

  // Stall the span output in changing moods, including calm stretches
  always @(negedge clk) begin
    logic nxt_stall;
    if (stall_span_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span_left = $urandom_range(16, 160);
    end else begin
      stall_span_left--;
    end
    case (stall_mode)
      STALL_NONE:  nxt_stall = 1'b0;
      STALL_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: nxt_stall = ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_run_left == 0) begin
          stall_held = ~stall_held;
          stall_run_left = $urandom_range(1, 12);
        end else begin
          stall_run_left--;
        end
        nxt_stall = stall_held;
      end
    endcase
    out_stall <= nxt_stall;
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (cfg_valid && cfg_ready) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= HangLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int placed, phase_len, k;
    logic [RadiusW-1:0] rad;

    // reset radius first, then the saturating and extreme settings
    add_circle(12'd0, 12'd0, 24'h000000);
    add_circle(12'd4095, 12'd4095, 24'hFFFFFF);
    add_circle(12'd0, 12'd4095, 24'hAAAAAA);
    add_circle(12'd4095, 12'd0, 24'h555555);
    add_radius(5'd0);
    add_circle(12'd2048, 12'd2048, 24'h123456);
    add_circle(12'd0, 12'd0, 24'hFFFFFF);
    add_radius(5'd1);
    add_circle(12'd4095, 12'd4095, 24'h000000);
    add_circle(12'd5, 12'd7, 24'hF0F0F0);
    add_radius(RadiusMax);
    add_circle(12'd0, 12'd0, 24'hFFFFFF);
    add_circle(12'd4095, 12'd4095, 24'h000000);
    add_circle(12'd15, 12'd4080, 24'h0F0F0F);
    add_circle(12'd2000, 12'd3000, 24'h808080);
    add_radius(5'd31);
    add_circle(12'd0, 12'd4095, 24'hFFFFFF);
    add_circle(12'd4095, 12'd0, 24'h000001);
    add_radius(5'd17);
    add_circle(12'd100, 12'd100, 24'h7FFFFF);
    add_radius(5'd3);
    add_circle(12'd0, 12'd0, 24'h800000);
    add_circle(12'd4095, 12'd4095, 24'hFFFFFE);

    // random phases, mostly small radii with the odd large or saturating one
    placed = 0;
    while (placed < RandomCircles) begin
      case ($urandom_range(0, 4))
        0, 1, 2: rad = RadiusW'($urandom_range(1, 6));
        3:       rad = RadiusW'($urandom_range(7, 16));
        default: rad = RadiusW'($urandom);
      endcase
      add_radius(rad);
      phase_len = $urandom_range(25, 50);
      for (k = 0; k < phase_len; k++)
        add_circle(pick_coord(), pick_coord(), ColourW'($urandom));
      placed += phase_len;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain everything, then allow for any stray words
    @(posedge clk);
    while (circle_jobs.size() != 0 || in_valid || cfg_valid || expected_spans.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (fail_count == 0 && expected_spans.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/fcsg_pkg.sv
hdl/fcsg_ctrl.sv
hdl/fcsg_datapath.sv
hdl/filled_circle_span_generator_unit.sv
dv/tb.sv
